/* rtl/ledfd_pkg.sv */
// Shared types, constants and prefix matching for the LED frame deframer.
package ledfd_pkg;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index taken from paddr[2]: registers sit at byte addresses 0 and 4.
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [1:0] MODE_SHORT   = 2'd0;
    localparam logic [1:0] MODE_CODED   = 2'd1;
    localparam logic [1:0] MODE_COUNTED = 2'd2;

    localparam logic [1:0]  MODE_RESET  = MODE_COUNTED;
    localparam logic [15:0] COUNT_RESET = 16'd96;

    localparam logic [7:0] PFX_SHORT_HI   = 8'hA5;
    localparam logic [7:0] PFX_SHORT_LO   = 8'h5A;
    localparam logic [7:0] PFX_CODED_HI   = 8'h5A;
    localparam logic [7:0] PFX_CODED_A1   = 8'hA1;
    localparam logic [7:0] PFX_CODED_A2   = 8'hA2;
    localparam logic [7:0] PFX_CODED_B0   = 8'hB0;
    localparam logic [7:0] PFX_CODED_B1   = 8'hB1;
    localparam logic [7:0] PFX_CODED_B2   = 8'hB2;
    localparam logic [7:0] PFX_COUNTED_HI = 8'hC9;
    localparam logic [7:0] PFX_COUNTED_LO = 8'hDA;

    localparam int FIFO_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] led_byte;
        logic       frame_last;
    } t_led_beat;

    typedef struct packed {
        logic      push;
        t_led_beat beat;
    } t_led_push;

    function automatic logic prefix_match(input logic [1:0] mode,
                                          input logic [7:0] first,
                                          input logic [7:0] second);
        logic hit;
        hit = 1'b0;
        case (mode)
            MODE_SHORT: begin
                hit = (first == PFX_SHORT_HI) && (second == PFX_SHORT_LO);
            end
            MODE_CODED: begin
                hit = (first == PFX_CODED_HI) &&
                      (second inside {PFX_CODED_A1, PFX_CODED_A2, PFX_CODED_B0,
                                      PFX_CODED_B1, PFX_CODED_B2});
            end
            MODE_COUNTED: begin
                hit = (first == PFX_COUNTED_HI) && (second == PFX_COUNTED_LO);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

endpackage

/* rtl/ledfd_rx_if.sv */
// Handshake channel carrying received serial bytes.
interface ledfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/ledfd_led_if.sv */
// Handshake channel carrying LED channel bytes with the end-of-frame mark.
interface ledfd_led_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_byte;
    logic       frame_last;

    modport source (output valid, output led_byte, output frame_last, input ready);
    modport sink   (input valid, input led_byte, input frame_last, output ready);
endinterface

/* rtl/ledfd_parser.sv */
// Front end: prefix hunt, count capture and channel byte tagging, one byte per cycle while the queue has space.
module ledfd_parser
    import ledfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_count,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_space,
    output logic        o_ready,
    output t_led_push   o_push
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_CNT_HI  = 3'd1;
    localparam logic [2:0] PH_CNT_LO  = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_POSTFIX = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic [15:0] r_remain, n_remain;
    logic [7:0]  r_cnt_hi, n_cnt_hi;
    logic        accept;
    logic [15:0] frame_len;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    always_comb begin
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_remain = r_remain;
        n_cnt_hi = r_cnt_hi;
        o_push.push            = 1'b0;
        o_push.beat.led_byte   = i_rx_byte;
        o_push.beat.frame_last = (r_remain == 16'd1);
        frame_len = (r_phase == PH_CNT_LO) ? {r_cnt_hi, i_rx_byte} : i_count;
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (prefix_match(i_mode, r_prev, i_rx_byte)) begin
                        n_prev = 8'd0;
                        if (i_mode == MODE_COUNTED) begin
                            n_phase = PH_CNT_HI;
                        end else begin
                            n_remain = frame_len;
                            n_phase  = (frame_len == 16'd0) ? PH_POSTFIX : PH_DATA;
                        end
                    end else begin
                        n_prev = i_rx_byte;
                    end
                end
                PH_CNT_HI: begin
                    n_cnt_hi = i_rx_byte;
                    n_phase  = PH_CNT_LO;
                end
                PH_CNT_LO: begin
                    n_remain = frame_len;
                    n_phase  = (frame_len == 16'd0) ? PH_POSTFIX : PH_DATA;
                end
                PH_DATA: begin
                    o_push.push = 1'b1;
                    n_remain    = r_remain - 16'd1;
                    if (r_remain == 16'd1) begin
                        n_phase = PH_POSTFIX;
                    end
                end
                default: begin
                    // Postfix byte: drop it and restart with an empty window.
                    n_phase = PH_HUNT;
                    n_prev  = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_prev   <= 8'd0;
            r_remain <= 16'd0;
            r_cnt_hi <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_remain <= n_remain;
            r_cnt_hi <= n_cnt_hi;
        end
    end

endmodule

/* rtl/ledfd_fifo.sv */
// Short queue between the parser and the output stage.
module ledfd_fifo
    import ledfd_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_led_push i_push,
    output logic      o_space,
    input  logic      i_pop,
    output logic      o_valid,
    output t_led_beat o_beat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_led_beat       r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_space = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign do_push = i_push.push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/ledfd_out.sv */
// Back end: output register that presents one channel beat to the LED side.
module ledfd_out
    import ledfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_led_beat   i_beat,
    output logic        o_pop,
    ledfd_led_if.source o_led
);

    logic      r_valid;
    t_led_beat r_beat;

    // Refill whenever the register is empty or its beat leaves this cycle.
    assign o_pop = i_valid && (!r_valid || o_led.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_led.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= i_beat;
        end
    end

    assign o_led.valid      = r_valid;
    assign o_led.led_byte   = r_beat.led_byte;
    assign o_led.frame_last = r_beat.frame_last;

endmodule

/* rtl/led_frame_deframer_top.sv */
// Path: a channel byte accepted by the parser is written into the queue, then into the output register.
// Throughput: one received byte per cycle while the queue has space; the parser updates its phase and count per byte.
// The two-entry queue and the output register hold three beats; while bytes stream in, an
// output stall fills the queue and then holds off the input.
// Reset (synchronous, active low) returns the parser to prefix hunting with an empty window,
// empties the queue and output register, and selects counted frames and a fixed length of 96.
module led_frame_deframer_top
    import ledfd_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ledfd_rx_if.sink          i_rx,
    ledfd_led_if.source       o_led,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [1:0]  r_mode;
    logic [15:0] r_count;
    logic        reg_idx;
    logic        wr_en;
    logic        fifo_space;
    logic        fifo_valid;
    logic        fifo_pop;
    t_led_push   parse_push;
    t_led_beat   fifo_beat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RESET;
            r_count <= COUNT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:  r_mode  <= pwdata[1:0];
                REG_COUNT: r_count <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:  prdata = {{(APB_DW-2){1'b0}}, r_mode};
            REG_COUNT: prdata = {{(APB_DW-16){1'b0}}, r_count};
            default:   prdata = '0;
        endcase
    end

    ledfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_count   (r_count),
        .i_valid   (i_rx.valid),
        .i_rx_byte (i_rx.rx_byte),
        .i_space   (fifo_space),
        .o_ready   (i_rx.ready),
        .o_push    (parse_push)
    );

    ledfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (parse_push),
        .o_space (fifo_space),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_beat  (fifo_beat)
    );

    ledfd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fifo_valid),
        .i_beat  (fifo_beat),
        .o_pop   (fifo_pop),
        .o_led   (o_led)
    );

endmodule

/* rtl/ledfd_checker.sv */
// Port-level checks for the LED frame deframer, bound to its top level.
module ledfd_checker
    import ledfd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rx_valid,
    input logic              i_rx_ready,
    input logic              i_led_valid,
    input logic              i_led_ready,
    input logic [7:0]        i_led_byte,
    input logic              i_led_frame_last,
    input logic              i_psel,
    input logic              i_penable,
    input logic              i_pwrite,
    input logic [APB_AW-1:0] i_paddr,
    input logic [APB_DW-1:0] i_pwdata,
    input logic [APB_DW-1:0] i_prdata
);

    // No beat may be pending in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_led_valid)
        else $error("output valid right after reset");

    // A stalled output beat holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_led_valid && !i_led_ready |=>
            i_led_valid && $stable(i_led_byte) && $stable(i_led_frame_last))
        else $error("stalled output beat changed");

    // A fresh output beat after an idle output stems from a byte taken in, queued and then registered for output.
    a_fresh_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_led_valid) |-> $past(i_rx_valid && i_rx_ready, 2))
        else $error("output beat without a matching input beat");

    // A channel count write reads back on the following cycle.
    a_count_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_paddr == 3'h4) ##1 (i_paddr == 3'h4) |->
            i_prdata[15:0] == $past(i_pwdata[15:0]))
        else $error("channel count readback mismatch");

endmodule

bind led_frame_deframer_top ledfd_checker u_ledfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rx_valid       (i_rx.valid),
    .i_rx_ready       (i_rx.ready),
    .i_led_valid      (o_led.valid),
    .i_led_ready      (o_led.ready),
    .i_led_byte       (o_led.led_byte),
    .i_led_frame_last (o_led.frame_last),
    .i_psel           (psel),
    .i_penable        (penable),
    .i_pwrite         (pwrite),
    .i_paddr          (paddr),
    .i_pwdata         (pwdata),
    .i_prdata         (prdata)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for led_frame_deframer_top: directed and random byte streams.
`timescale 1ns / 1ps

module tb_top;
    import ledfd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Tracks the parser state, predicts every LED beat and checks what comes out.
    class led_frame_checker;
        typedef enum logic [2:0] {SCAN, LEN_HI, LEN_LO, PAYLOAD, TRAILER} t_parse_state;

        logic [1:0]   mode;
        logic [15:0]  count_reg;
        t_parse_state state;
        logic [7:0]   window_byte;
        logic [15:0]  left;
        logic [7:0]   len_hi;
        t_led_beat    pending_beats[$];
        int           errors;

        function new();
            mode        = MODE_RESET;
            count_reg   = COUNT_RESET;
            state       = SCAN;
            window_byte = 8'h00;
            left        = 16'd0;
            len_hi      = 8'h00;
            errors      = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] val);
            if (idx == REG_MODE) begin
                mode = val[1:0];
            end else begin
                count_reg = val[15:0];
            end
        endfunction

        function bit prefix_hit(logic [7:0] a, logic [7:0] b);
            case (mode)
                MODE_SHORT: begin
                    return a == PFX_SHORT_HI && b == PFX_SHORT_LO;
                end
                MODE_CODED: begin
                    return a == PFX_CODED_HI &&
                           (b == PFX_CODED_A1 || b == PFX_CODED_A2 || b == PFX_CODED_B0 ||
                            b == PFX_CODED_B1 || b == PFX_CODED_B2);
                end
                MODE_COUNTED: begin
                    return a == PFX_COUNTED_HI && b == PFX_COUNTED_LO;
                end
                default: begin
                    return 1'b0;
                end
            endcase
        endfunction

        function void open_payload(logic [15:0] n);
            left  = n;
            state = (n == 16'd0) ? TRAILER : PAYLOAD;
        endfunction

        function void take_rx_byte(logic [7:0] b);
            t_led_beat beat;
            case (state)
                SCAN: begin
                    if (prefix_hit(window_byte, b)) begin
                        window_byte = 8'h00;
                        if (mode == MODE_COUNTED) begin
                            state = LEN_HI;
                        end else begin
                            open_payload(count_reg);
                        end
                    end else begin
                        window_byte = b;
                    end
                end
                LEN_HI: begin
                    len_hi = b;
                    state  = LEN_LO;
                end
                LEN_LO: begin
                    open_payload({len_hi, b});
                end
                PAYLOAD: begin
                    left            = left - 16'd1;
                    beat.led_byte   = b;
                    beat.frame_last = (left == 16'd0);
                    pending_beats.push_back(beat);
                    if (left == 16'd0) begin
                        state = TRAILER;
                    end
                end
                default: begin
                    // The postfix byte is dropped and the window starts empty again.
                    state       = SCAN;
                    window_byte = 8'h00;
                end
            endcase
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] ERROR: %s", $realtime, msg);
            end
        endfunction

        function void check_led_beat(t_led_beat got);
            t_led_beat exp;
            if (pending_beats.size() == 0) begin
                note_error($sformatf("unexpected beat led_byte=%02h frame_last=%0b",
                                     got.led_byte, got.frame_last));
                return;
            end
            exp = pending_beats.pop_front();
            if (got.led_byte !== exp.led_byte) begin
                note_error($sformatf("led_byte expected %02h got %02h",
                                     exp.led_byte, got.led_byte));
            end
            if (got.frame_last !== exp.frame_last) begin
                note_error($sformatf("frame_last expected %0b got %0b (led_byte %02h)",
                                     exp.frame_last, got.frame_last, exp.led_byte));
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              calm;
    int                sent_bytes;

    led_frame_checker sb = new();

    ledfd_rx_if  rx_ch();
    ledfd_led_if led_ch();

    led_frame_deframer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_led   (led_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // LED side: check every accepted beat, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && led_ch.valid === 1'b1 && led_ch.ready === 1'b1) begin
            sb.check_led_beat({led_ch.led_byte, led_ch.frame_last});
        end
        led_ch.ready <= calm || ($urandom_range(99) >= 34);
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 34) begin
                gap++;
            end
        end
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        sb.take_rx_byte(b);
        sent_bytes++;
    endtask

    // Stop sending, let every expected beat drain, then allow the pipeline to go quiet.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] coded_second();
        case ($urandom_range(4))
            0: return PFX_CODED_A1;
            1: return PFX_CODED_A2;
            2: return PFX_CODED_B0;
            3: return PFX_CODED_B1;
            default: return PFX_CODED_B2;
        endcase
    endfunction

    // Bytes between frames lean toward prefix values to provoke near misses.
    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        case ($urandom_range(3))
            0: v = 8'($urandom_range(255));
            1: v = ($urandom_range(1) != 0) ? PFX_SHORT_HI : PFX_COUNTED_HI;
            2: v = ($urandom_range(1) != 0) ? PFX_SHORT_LO : coded_second();
            default: v = 8'h00;
        endcase
        // A stray counted prefix would pull a random length from the stream.
        if (sb.mode == MODE_COUNTED && v == PFX_COUNTED_HI) begin
            v = 8'h00;
        end
        return v;
    endfunction

    task automatic send_frame();
        logic [7:0] lead;
        logic [7:0] second;
        logic [7:0] len;
        int         n;
        repeat ($urandom_range(3)) send_byte(noise_byte());
        if (sb.mode == MODE_UNUSED) begin
            repeat (6) send_byte(8'($urandom_range(255)));
            return;
        end
        case (sb.mode)
            MODE_SHORT: begin
                lead   = PFX_SHORT_HI;
                second = PFX_SHORT_LO;
            end
            MODE_CODED: begin
                lead   = PFX_CODED_HI;
                second = coded_second();
            end
            default: begin
                lead   = PFX_COUNTED_HI;
                second = PFX_COUNTED_LO;
            end
        endcase
        if ($urandom_range(9) == 0) begin
            // Broken prefix: right first byte, wrong second byte.
            do second = 8'($urandom_range(255));
            while (sb.prefix_hit(lead, second) || second == PFX_COUNTED_HI);
            send_byte(lead);
            send_byte(second);
            return;
        end
        send_byte(lead);
        send_byte(second);
        n = int'(sb.count_reg);
        if (sb.mode == MODE_COUNTED) begin
            len = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
            send_byte(8'h00);
            send_byte(len);
            n = int'(len);
        end
        repeat (n) send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        int         frame_no;
        int         i;
        int         r;
        logic [1:0] m;

        i_rst_n       = 1'b0;
        calm          = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        led_ch.ready  = 1'b0;
        sent_bytes    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Counted frame from reset settings, byte extremes as data.
        send_byte(PFX_COUNTED_HI);
        send_byte(PFX_COUNTED_LO);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7E);
        // Zero length goes to the postfix; a prefix byte as postfix must not open a window.
        send_byte(PFX_COUNTED_HI);
        send_byte(PFX_COUNTED_LO);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(PFX_COUNTED_HI);
        send_byte(PFX_COUNTED_LO);
        settle();

        reg_write(REG_MODE, 32'(MODE_SHORT));
        reg_write(REG_COUNT, 32'd1);
        send_byte(PFX_SHORT_HI);
        send_byte(PFX_SHORT_LO);
        send_byte(8'h80);
        send_byte(8'h00);
        settle();

        reg_write(REG_MODE, 32'(MODE_CODED));
        reg_write(REG_COUNT, 32'd0);
        send_byte(PFX_CODED_HI);
        send_byte(PFX_CODED_B2);
        send_byte(8'hAA);
        settle();

        // Mode and count change while a frame is open: the frame keeps its latched path.
        reg_write(REG_COUNT, 32'd3);
        send_byte(PFX_CODED_HI);
        send_byte(PFX_CODED_A1);
        send_byte(8'h01);
        settle();
        reg_write(REG_MODE, 32'(MODE_COUNTED));
        reg_write(REG_COUNT, 32'hFFFF);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h44);
        settle();

        // A counted length whose high byte is not zero.
        send_byte(PFX_COUNTED_HI);
        send_byte(PFX_COUNTED_LO);
        send_byte(8'h01);
        send_byte(8'h02);
        repeat (258) send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        settle();

        // The unused mode never finds a prefix.
        reg_write(REG_MODE, 32'(MODE_UNUSED));
        send_byte(PFX_COUNTED_HI);
        send_byte(PFX_COUNTED_LO);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h55);

        frame_no = 0;
        while (sent_bytes < 750) begin
            if (frame_no % 8 == 0) begin
                settle();
                r = $urandom_range(9);
                m = (r < 3) ? MODE_SHORT : (r < 6) ? MODE_CODED :
                    (r < 9) ? MODE_COUNTED : MODE_UNUSED;
                reg_write(REG_MODE, 32'(m));
                reg_write(REG_COUNT, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12));
            end
            calm = (frame_no >= 12 && frame_no < 24);
            send_frame();
            frame_no++;
        end
        calm = 1'b0;

        rx_ch.valid <= 1'b0;
        for (i = 0; i < 5000 && sb.pending() != 0; i++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.note_error($sformatf("%0d expected beats never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ledfd_pkg.sv
rtl/ledfd_rx_if.sv
rtl/ledfd_led_if.sv
rtl/ledfd_parser.sv
rtl/ledfd_fifo.sv
rtl/ledfd_out.sv
rtl/led_frame_deframer_top.sv
rtl/ledfd_checker.sv
tb/sv/tb_top.sv
